@@ src/mfde_pkg.sv @@
// shared constants, types and address helpers for the frame buffer draw engine
// no dependencies
package mfde_pkg;

   localparam int COLUMNS  = 128;
   localparam int PAGES    = 8;
   localparam int ROWS     = PAGES * 8;
   localparam int FB_DEPTH = COLUMNS * PAGES;
   localparam int FB_AW    = $clog2(FB_DEPTH);

   typedef logic [2:0] func_type;

   localparam func_type FUNC_LINE   = 3'd0;
   localparam func_type FUNC_RECT   = 3'd1;
   localparam func_type FUNC_FILL   = 3'd2;
   localparam func_type FUNC_CIRCLE = 3'd3;
   localparam func_type FUNC_CLEAR  = 3'd4;
   localparam func_type FUNC_READ   = 3'd5;

   typedef struct packed {
      logic load;
      logic step;
   } line_ctl_type;

   typedef struct packed {
      logic last;
   } line_sts_type;

   // byte address of the page byte holding pixel (x, y)
   function automatic logic [FB_AW-1:0] pix_addr(input logic [7:0] x, input logic [7:0] y);
      int a;
      a = int'(x) * PAGES + int'(y[7:3]);
      return FB_AW'(a);
   endfunction

   // pixel lies inside the visible area
   function automatic logic on_screen(input logic [7:0] x, input logic [7:0] y);
      return (int'(x) < COLUMNS) && (int'(y) < ROWS);
   endfunction

endpackage

@@ src/monochrome_framebuffer_draw_engine_core.sv @@
// draw engine top level: command sequencer, circle walker, pixel read-modify-write
// each plotted pixel is a frame buffer read, then a write back
// throughput: one command at a time; busy stays high until the result beat
// reset: a clearing pass zeroes every frame buffer address, busy high meanwhile
// the result beat is a one-cycle strobe; the receiver cannot stall
// depends on mfde_pkg, mfde_ram, mfde_line
module monochrome_framebuffer_draw_engine_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mfde_pkg::func_type  req_func,
   input  logic [7:0]          req_start_x,
   input  logic [7:0]          req_start_y,
   input  logic [7:0]          req_end_x_or_width,
   input  logic [7:0]          req_end_y_or_height,
   input  logic                req_set_pixels,
   input  logic [6:0]          req_read_column,
   input  logic [2:0]          req_read_page,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_read_data
);
   import mfde_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RDOUT, S_LOAD, S_PRD, S_PWR, S_CCHK, S_CUPD
   } state_type;

   state_type  state_ff, state_in;
   func_type   func_ff, func_in;
   logic [7:0] x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic       on_ff, on_in;
   logic [1:0] seg_ff, seg_in;
   logic [7:0] row_ff, row_in;
   logic [2:0] k_ff, k_in;
   logic [7:0] a_ff, a_in, b_ff, b_in;
   logic [15:0] aa_ff, aa_in, bb_ff, bb_in, rr_ff, rr_in;
   logic       zero_ff, zero_in, rd_ok_ff, rd_ok_in, clr_rsp_ff, clr_rsp_in;
   logic [FB_AW-1:0] clr_ff, clr_in;
   logic       strobe_ff, strobe_in;
   logic [7:0] data_ff, data_in;

   logic [15:0] prod;
   logic [17:0] chk_sum;
   logic [7:0]  xw, yh, yi;
   logic [7:0]  lx1, ly1, lx2, ly2;
   logic [7:0]  cpx, cpy, px, py, wx, wy;
   logic        circ_mode;
   logic [FB_AW-1:0] raddr, waddr;
   logic        we;
   logic [7:0]  wdata, rdata, bitmask;
   line_ctl_type lctl;
   line_sts_type lsts;

   mfde_ram #(.WIDTH(8), .DEPTH(FB_DEPTH)) u_fb (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   mfde_line u_line (
      .clock (clock),
      .reset (reset),
      .ctl   (lctl),
      .x1    (lx1),
      .y1    (ly1),
      .x2    (lx2),
      .y2    (ly2),
      .cur_x (wx),
      .cur_y (wy),
      .sts   (lsts)
   );

   // line endpoints for each command and segment
   assign xw = x_ff + w_ff;
   assign yh = y_ff + h_ff;
   assign yi = y_ff + row_ff;
   always_comb begin
      lx1 = x_ff; ly1 = y_ff; lx2 = w_ff; ly2 = h_ff;
      case (func_ff)
         FUNC_RECT: begin
            case (seg_ff)
               2'd0: begin lx1 = x_ff; ly1 = y_ff; lx2 = xw;   ly2 = y_ff; end
               2'd1: begin lx1 = xw;   ly1 = y_ff; lx2 = xw;   ly2 = yh;   end
               2'd2: begin lx1 = x_ff; ly1 = y_ff; lx2 = x_ff; ly2 = yh;   end
               default: begin lx1 = x_ff; ly1 = yh; lx2 = xw;  ly2 = yh;   end
            endcase
         end
         FUNC_FILL: begin
            lx1 = x_ff; ly1 = yi; lx2 = xw; ly2 = yi;
         end
         default: ;
      endcase
   end

   // eight-way symmetric circle point
   always_comb begin
      case (k_ff)
         3'd0: begin cpx = x_ff + a_ff; cpy = y_ff - b_ff; end
         3'd1: begin cpx = x_ff - a_ff; cpy = y_ff - b_ff; end
         3'd2: begin cpx = x_ff - a_ff; cpy = y_ff + b_ff; end
         3'd3: begin cpx = x_ff + a_ff; cpy = y_ff + b_ff; end
         3'd4: begin cpx = x_ff + b_ff; cpy = y_ff + a_ff; end
         3'd5: begin cpx = x_ff + b_ff; cpy = y_ff - a_ff; end
         3'd6: begin cpx = x_ff - b_ff; cpy = y_ff - a_ff; end
         default: begin cpx = x_ff - b_ff; cpy = y_ff + a_ff; end
      endcase
   end

   // pixel under read-modify-write
   assign circ_mode = func_ff == FUNC_CIRCLE;
   assign px        = circ_mode ? cpx : wx;
   assign py        = circ_mode ? cpy : wy;
   assign bitmask   = 8'd1 << py[2:0];

   assign prod    = 16'(req_end_x_or_width) * 16'(req_end_x_or_width);
   assign chk_sum = 18'(aa_ff) + 18'({a_ff, 1'b1}) + 18'(bb_ff);

   // frame buffer ports
   always_comb begin
      raddr = pix_addr(px, py);
      if (state_ff == S_IDLE) begin
         raddr = FB_AW'(int'(req_read_column) * PAGES + int'(req_read_page));
      end
      we    = 1'b0;
      waddr = pix_addr(px, py);
      wdata = (on_ff || circ_mode) ? (rdata | bitmask) : (rdata & ~bitmask);
      if (state_ff == S_CLEAR) begin
         we    = 1'b1;
         waddr = clr_ff;
         wdata = '0;
      end else if (state_ff == S_PWR) begin
         we = on_screen(px, py);
      end
   end

   // command sequencer
   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      on_in      = on_ff;
      seg_in     = seg_ff;
      row_in     = row_ff;
      k_in       = k_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      aa_in      = aa_ff;
      bb_in      = bb_ff;
      rr_in      = rr_ff;
      zero_in    = zero_ff;
      rd_ok_in   = rd_ok_ff;
      clr_in     = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      strobe_in  = 1'b0;
      data_in    = '0;
      lctl       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + FB_AW'(1);
            if (int'(clr_ff) == FB_DEPTH - 1) begin
               strobe_in = clr_rsp_ff;
               state_in  = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               func_in = req_func;
               x_in    = req_start_x;
               y_in    = req_start_y;
               w_in    = req_end_x_or_width;
               h_in    = req_end_y_or_height;
               on_in   = req_set_pixels;
               seg_in  = '0;
               row_in  = '0;
               k_in    = '0;
               unique case (req_func)
                  FUNC_LINE, FUNC_RECT, FUNC_FILL: state_in = S_LOAD;
                  FUNC_CIRCLE: begin
                     a_in     = '0;
                     b_in     = req_end_x_or_width;
                     aa_in    = '0;
                     bb_in    = prod;
                     rr_in    = prod;
                     zero_in  = req_end_x_or_width == 8'd0;
                     state_in = (req_end_x_or_width == 8'd0) ? S_PRD : S_CCHK;
                  end
                  FUNC_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  FUNC_READ: begin
                     rd_ok_in = (int'(req_read_column) < COLUMNS) &&
                                (int'(req_read_page) < PAGES);
                     state_in = S_RDOUT;
                  end
                  default: begin
                     rd_ok_in = 1'b0;
                     state_in = S_RDOUT;
                  end
               endcase
            end
         end
         S_RDOUT: begin
            strobe_in = 1'b1;
            data_in   = rd_ok_ff ? rdata : 8'd0;
            state_in  = S_IDLE;
         end
         S_LOAD: begin
            lctl.load = 1'b1;
            state_in  = S_PRD;
         end
         S_PRD: state_in = S_PWR;
         S_PWR: begin
            state_in = S_PRD;
            if (circ_mode) begin
               k_in = k_ff + 3'd1;
               if (zero_ff) begin
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else if (k_ff == 3'd7) begin
                  state_in = S_CUPD;
               end
            end else if (!lsts.last) begin
               lctl.step = 1'b1;
            end else if (func_ff == FUNC_RECT && seg_ff != 2'd3) begin
               seg_in   = seg_ff + 2'd1;
               state_in = S_LOAD;
            end else if (func_ff == FUNC_FILL && row_ff != h_ff) begin
               row_in   = row_ff + 8'd1;
               state_in = S_LOAD;
            end else begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_CCHK: begin
            if ({bb_ff, 1'b0} >= 17'(rr_ff)) begin
               state_in = S_PRD;
            end else begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_CUPD: begin
            // step a, or step b back when the point leaves the circle
            if (chk_sum > 18'(rr_ff)) begin
               b_in  = b_ff - 8'd1;
               bb_in = bb_ff - 16'({b_ff, 1'b0}) + 16'd1;
            end else begin
               a_in  = a_ff + 8'd1;
               aa_in = 16'(chk_sum - 18'(bb_ff));
            end
            state_in = S_CCHK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         strobe_ff  <= 1'b0;
         data_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         strobe_ff  <= strobe_in;
         data_ff    <= data_in;
      end
      func_ff  <= func_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      on_ff    <= on_in;
      seg_ff   <= seg_in;
      row_ff   <= row_in;
      k_ff     <= k_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      aa_ff    <= aa_in;
      bb_ff    <= bb_in;
      rr_ff    <= rr_in;
      zero_ff  <= zero_in;
      rd_ok_ff <= rd_ok_in;
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_strobe    = strobe_ff;
   assign rsp_read_data = data_ff;

   // result beat only ever follows a busy cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("result beat without a command in flight");

   // read data is zero outside a result beat
   a_data_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |-> rsp_read_data == 8'd0) else $error("read data driven outside a beat");

   // frame buffer is only written while busy
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      we |-> busy) else $error("frame buffer write while idle");

endmodule

@@ src/mfde_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module mfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ src/mfde_line.sv @@
// dda line walker: holds cursor, error sums and point count
// depends on mfde_pkg
module mfde_line (
   input  logic                  clock,
   input  logic                  reset,
   input  mfde_pkg::line_ctl_type ctl,
   input  logic [7:0]            x1,
   input  logic [7:0]            y1,
   input  logic [7:0]            x2,
   input  logic [7:0]            y2,
   output logic [7:0]            cur_x,
   output logic [7:0]            cur_y,
   output mfde_pkg::line_sts_type sts
);
   import mfde_pkg::*;

   logic [7:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [9:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [7:0] dx_ff, dx_in, dy_ff, dy_in, dist_ff, dist_in, n_ff, n_in;
   logic       xneg_ff, xneg_in, yneg_ff, yneg_in;
   logic [9:0] ex_sum, ey_sum;

   // next walker state
   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      ex_in   = ex_ff;
      ey_in   = ey_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      dist_in = dist_ff;
      n_in    = n_ff;
      xneg_in = xneg_ff;
      yneg_in = yneg_ff;
      ex_sum  = ex_ff + 10'(dx_ff);
      ey_sum  = ey_ff + 10'(dy_ff);
      if (ctl.load) begin
         xneg_in = x2 < x1;
         yneg_in = y2 < y1;
         dx_in   = (x2 < x1) ? x1 - x2 : x2 - x1;
         dy_in   = (y2 < y1) ? y1 - y2 : y2 - y1;
         dist_in = (dx_in > dy_in) ? dx_in : dy_in;
         cx_in   = x1;
         cy_in   = y1;
         ex_in   = '0;
         ey_in   = '0;
         n_in    = '0;
      end else if (ctl.step) begin
         ex_in = ex_sum;
         ey_in = ey_sum;
         if (ex_sum > 10'(dist_ff)) begin
            ex_in = ex_sum - 10'(dist_ff);
            cx_in = xneg_ff ? cx_ff - 8'd1 : cx_ff + 8'd1;
         end
         if (ey_sum > 10'(dist_ff)) begin
            ey_in = ey_sum - 10'(dist_ff);
            cy_in = yneg_ff ? cy_ff - 8'd1 : cy_ff + 8'd1;
         end
         n_in = n_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         ex_ff <= '0;
         ey_ff <= '0;
         n_ff  <= '0;
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         ex_ff <= ex_in;
         ey_ff <= ey_in;
         n_ff  <= n_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dist_ff <= dist_in;
      xneg_ff <= xneg_in;
      yneg_ff <= yneg_in;
   end

   assign cur_x    = cx_ff;
   assign cur_y    = cy_ff;
   assign sts.last = n_ff == dist_ff;

endmodule
